// File: rtl/ftrm_pkg.sv
// shared types, constants and rounding helpers for the from-to rotation matrix block
// no dependencies; imported by every module of the block
package ftrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int EPS_W     = 15;
  localparam int EPS_RESET = 16;

  // queue between front and back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // shared divider and square root widths
  localparam int DIV_NUM_W  = 62;
  localparam int DIV_DEN_W  = 42;
  localparam int DIV_QUO_W  = 26;
  localparam int SQRT_IN_W  = 62;
  localparam int SQRT_OUT_W = 31;

  // item field widths
  localparam int V_W  = 33;
  localparam int VF_W = 19;
  localparam int EF_W = 20;
  localparam int FR_W = 18;
  localparam int LL_W = 32;

  typedef enum logic [1:0] {
    CASE_GENERAL  = 2'd0,
    CASE_PARALLEL = 2'd1,
    CASE_ANTI     = 2'd2
  } case_t;

  typedef struct packed {
    case_t                     code;
    logic [2:0][15:0]          f;
    logic [2:0][V_W-1:0]       v;
    logic [2:0][VF_W-1:0]      vf;
    logic [EF_W-1:0]           ef;
    logic [5:0][FR_W-1:0]      ffr;
    logic                      left_alt;
    logic [LL_W-1:0]           ll;
  } ftrm_item_t;

  // round to nearest, halves away from zero, s at least one
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return 16'h7fff;
    end else if (x < -64'sd32768) begin
      return 16'h8000;
    end
    return x[15:0];
  endfunction

endpackage

// File: rtl/ftrm_front.sv
// front end: registers the component products, forms the cross and dot products, classifies the pair and
// builds the queue entry; depends on ftrm_pkg
module ftrm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            from_x,
  input  logic signed [15:0]            from_y,
  input  logic signed [15:0]            from_z,
  input  logic signed [15:0]            to_x,
  input  logic signed [15:0]            to_y,
  input  logic signed [15:0]            to_z,
  input  logic [ftrm_pkg::EPS_W-1:0]    epsilon,
  input  logic [ftrm_pkg::QCNT_W-1:0]   q_count,
  output logic                          push,
  output ftrm_pkg::ftrm_item_t          item
);
  import ftrm_pkg::*;

  localparam logic signed [34:0] ONE2 = $signed(35'(1) << (2 * FRAC_BITS));

  logic                s1_valid;
  logic [2:0][15:0]    s1_f;
  logic signed [31:0]  p_f1t2, p_f2t1, p_f2t0, p_f0t2, p_f0t1, p_f1t0;
  logic signed [31:0]  p_dot0, p_dot1, p_dot2;
  logic signed [31:0]  p_ff00, p_ff01, p_ff02, p_ff11, p_ff12, p_ff22;

  logic signed [V_W-1:0] v0, v1, v2;
  logic signed [33:0]    e;
  logic signed [34:0]    epsf;
  logic [31:0]           eps32;
  logic [31:0]           sq12;
  logic                  is_par;
  logic                  is_anti;
  logic                  alt;

  // one slot of the queue is reserved for the item in flight
  assign in_ready = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid)) < (QCNT_W+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_f   <= {from_z, from_y, from_x};
      p_f1t2 <= 32'(from_y) * 32'(to_z);
      p_f2t1 <= 32'(from_z) * 32'(to_y);
      p_f2t0 <= 32'(from_z) * 32'(to_x);
      p_f0t2 <= 32'(from_x) * 32'(to_z);
      p_f0t1 <= 32'(from_x) * 32'(to_y);
      p_f1t0 <= 32'(from_y) * 32'(to_x);
      p_dot0 <= 32'(from_x) * 32'(to_x);
      p_dot1 <= 32'(from_y) * 32'(to_y);
      p_dot2 <= 32'(from_z) * 32'(to_z);
      p_ff00 <= 32'(from_x) * 32'(from_x);
      p_ff01 <= 32'(from_x) * 32'(from_y);
      p_ff02 <= 32'(from_x) * 32'(from_z);
      p_ff11 <= 32'(from_y) * 32'(from_y);
      p_ff12 <= 32'(from_y) * 32'(from_z);
      p_ff22 <= 32'(from_z) * 32'(from_z);
    end
  end

  always_comb begin
    v0    = V_W'(p_f1t2) - V_W'(p_f2t1);
    v1    = V_W'(p_f2t0) - V_W'(p_f0t2);
    v2    = V_W'(p_f0t1) - V_W'(p_f1t0);
    e     = 34'(p_dot0) + 34'(p_dot1) + 34'(p_dot2);
    epsf  = $signed(35'({epsilon, {FRAC_BITS{1'b0}}}));
    eps32 = 32'({epsilon, {FRAC_BITS{1'b0}}});
    is_par  = 35'(e) > (ONE2 - epsf);
    is_anti = 35'(e) < (epsf - ONE2);
    sq12  = $unsigned(p_ff11) + $unsigned(p_ff22);
    alt   = sq12 < eps32;

    push          = s1_valid;
    item.code     = is_par ? CASE_PARALLEL : (is_anti ? CASE_ANTI : CASE_GENERAL);
    item.f        = s1_f;
    item.v        = {v2, v1, v0};
    item.vf[0]    = VF_W'(rnd_shift(64'(v0), FRAC_BITS));
    item.vf[1]    = VF_W'(rnd_shift(64'(v1), FRAC_BITS));
    item.vf[2]    = VF_W'(rnd_shift(64'(v2), FRAC_BITS));
    item.ef       = EF_W'(rnd_shift(64'(e), FRAC_BITS));
    item.ffr[0]   = FR_W'(rnd_shift(64'(p_ff00), FRAC_BITS));
    item.ffr[1]   = FR_W'(rnd_shift(64'(p_ff01), FRAC_BITS));
    item.ffr[2]   = FR_W'(rnd_shift(64'(p_ff02), FRAC_BITS));
    item.ffr[3]   = FR_W'(rnd_shift(64'(p_ff11), FRAC_BITS));
    item.ffr[4]   = FR_W'(rnd_shift(64'(p_ff12), FRAC_BITS));
    item.ffr[5]   = FR_W'(rnd_shift(64'(p_ff22), FRAC_BITS));
    item.left_alt = alt;
    // squared length of the chosen left vector
    item.ll       = alt ? ($unsigned(p_ff22) + $unsigned(p_ff00)) : sq12;
  end

endmodule

// File: rtl/ftrm_queue.sv
// short fifo between the front and back end
// depends on ftrm_pkg
module ftrm_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  ftrm_pkg::ftrm_item_t          wdata,
  input  logic                          pop,
  output ftrm_pkg::ftrm_item_t          rdata,
  output logic [ftrm_pkg::QCNT_W-1:0]   count
);
  import ftrm_pkg::*;

  ftrm_item_t          mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/ftrm_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on ftrm_pkg
module ftrm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ftrm_pkg::DIV_NUM_W-1:0]   num,
  input  logic [ftrm_pkg::DIV_DEN_W-1:0]   den,
  output logic                             done,
  output logic [ftrm_pkg::DIV_QUO_W-1:0]   quo
);
  import ftrm_pkg::*;

  localparam int WIDE_W = DIV_NUM_W + DIV_QUO_W;
  localparam int K_W    = $clog2(DIV_QUO_W);

  logic                   busy;
  logic [K_W-1:0]         k;
  logic [DIV_NUM_W-1:0]   rem;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [WIDE_W-1:0]      den_sh;
  logic [WIDE_W-1:0]      rem_w;
  logic                   fits;

  always_comb begin
    den_sh = WIDE_W'(den_r) << k;
    rem_w  = WIDE_W'(rem);
    fits   = rem_w >= den_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= num;
        den_r <= den;
        quo   <= '0;
        k     <= K_W'(DIV_QUO_W - 1);
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_NUM_W'(rem_w - den_sh);
          quo <= quo | (DIV_QUO_W'(1) << k);
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - K_W'(1);
        end
      end
    end
  end

endmodule

// File: rtl/ftrm_sqrt.sv
// integer square root by digit recurrence, one result bit per cycle
// depends on ftrm_pkg
module ftrm_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ftrm_pkg::SQRT_IN_W-1:0]    x,
  output logic                              done,
  output logic [ftrm_pkg::SQRT_OUT_W-1:0]   root
);
  import ftrm_pkg::*;

  logic        busy;
  logic [4:0]  step;
  logic [63:0] xr;
  logic [63:0] r;
  logic [63:0] b;
  logic [63:0] rb;

  assign rb   = r + b;
  assign root = r[SQRT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xr   <= 64'(x);
        r    <= '0;
        b    <= 64'd1 << 62;
        step <= 5'd31;
      end else if (busy) begin
        if (xr >= rb) begin
          xr <= xr - rb;
          r  <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (step == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 5'd1;
        end
      end
    end
  end

endmodule

// File: rtl/ftrm_back.sv
// back end: sequencer that works out the matrix of one queued item with a
// shared multiplier, divider and square root; depends on ftrm_pkg,
// ftrm_div and ftrm_sqrt
module ftrm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  ftrm_pkg::ftrm_item_t   q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     m00,
  output logic signed [15:0]     m01,
  output logic signed [15:0]     m02,
  output logic signed [15:0]     m10,
  output logic signed [15:0]     m11,
  output logic signed [15:0]     m12,
  output logic signed [15:0]     m20,
  output logic signed [15:0]     m21,
  output logic signed [15:0]     m22,
  output logic [1:0]             case_code
);
  import ftrm_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE, B_DONE,
    G_SHIFT, G_VV_MUL, G_VV_ACC, G_Q_MUL, G_Q_DIV, G_Q_WAIT, G_T_MUL, G_T_ACC,
    A_SQ_GO, A_SQ_WAIT, A_LN_DIV, A_LN_WAIT,
    A_UP_MUL1, A_UP_MUL2, A_UP_ACC, A_M_MUL1, A_M_MUL2, A_M_ACC
  } state_t;

  localparam logic signed [27:0] ONE28 = $signed(28'(1) << FRAC_BITS);

  state_t               state;
  ftrm_item_t           it;
  logic [2:0][31:0]     wm;
  logic [2:0]           ws;
  logic [DIV_DEN_W-1:0] vv;
  logic [2:0]           cnt;
  logic signed [63:0]   prod;
  logic signed [47:0]   acc;
  logic signed [21:0]   qv;
  logic                 qsign;
  logic [SQRT_OUT_W-1:0] root;
  logic [2:0][26:0]     ln;
  logic [2:0][28:0]     up;
  logic [5:0][23:0]     m6;

  logic signed [31:0]   mul_a, mul_b;
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_QUO_W-1:0] div_quo;
  logic                 sq_start, sq_done;
  logic [SQRT_OUT_W-1:0] sq_root;

  logic [1:0]           pi, pj, na, nb;
  logic signed [20:0]   wi, wj;
  logic signed [20:0]   d;
  logic [63:0]          pmag;
  logic signed [16:0]   lk;
  logic [15:0]          lmag;
  logic                 shift_more;
  logic signed [27:0]   mr [9];

  function automatic logic [1:0] pair_i(input logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd2: return 2'd0;
      3'd3, 3'd4:       return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_j(input logic [2:0] p);
    case (p)
      3'd0:       return 2'd0;
      3'd1, 3'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] next1(input logic [1:0] k);
    case (k)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] next2(input logic [1:0] k);
    case (k)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  // left vector component, perpendicular to from
  function automatic logic signed [16:0] left_comp(input ftrm_item_t x, input logic [1:0] k);
    logic signed [16:0] f0, f1, f2;
    f0 = 17'($signed(x.f[0]));
    f1 = 17'($signed(x.f[1]));
    f2 = 17'($signed(x.f[2]));
    if (x.left_alt) begin
      case (k)
        2'd0:    return -f2;
        2'd1:    return '0;
        default: return f0;
      endcase
    end
    case (k)
      2'd0:    return '0;
      2'd1:    return f2;
      default: return -f1;
    endcase
  endfunction

  ftrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  ftrm_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (SQRT_IN_W'(it.ll) << 30),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_comb begin
    pi   = pair_i(cnt);
    pj   = pair_j(cnt);
    na   = next1(cnt[1:0]);
    nb   = next2(cnt[1:0]);
    wi   = ws[pi] ? -21'(wm[pi][19:0]) : 21'(wm[pi][19:0]);
    wj   = ws[pj] ? -21'(wm[pj][19:0]) : 21'(wm[pj][19:0]);
    d    = $signed(21'(1) << FRAC_BITS) - 21'($signed(it.ef));
    pmag = prod[63] ? 64'(-prod) : 64'(prod);
    lk   = left_comp(it, cnt[1:0]);
    lmag = 16'(lk[16] ? -lk : lk);
    shift_more = (|wm[0][31:20]) | (|wm[1][31:20]) | (|wm[2][31:20]);

    q_pop     = (state == B_IDLE) && q_valid;
    sq_start  = (state == A_SQ_GO);
    div_start = ((state == G_Q_DIV) && (vv != '0)) ||
                ((state == A_LN_DIV) && (it.ll != '0));
    if (state == A_LN_DIV) begin
      div_num = (DIV_NUM_W'(lmag) << 39) + DIV_NUM_W'(root >> 1);
      div_den = DIV_DEN_W'(root);
    end else begin
      div_num = (DIV_NUM_W'(pmag[39:0]) << 20) + DIV_NUM_W'(vv >> 1);
      div_den = vv;
    end

    case (state)
      G_VV_MUL: begin
        mul_a = $signed(wm[cnt[1:0]]);
        mul_b = $signed(wm[cnt[1:0]]);
      end
      G_Q_MUL: begin
        mul_a = 32'(wi);
        mul_b = 32'(wj);
      end
      G_T_MUL: begin
        mul_a = 32'(d);
        mul_b = 32'(qv);
      end
      A_UP_MUL1: begin
        mul_a = 32'($signed(ln[na]));
        mul_b = 32'($signed(it.f[nb]));
      end
      A_UP_MUL2: begin
        mul_a = 32'($signed(ln[nb]));
        mul_b = 32'($signed(it.f[na]));
      end
      A_M_MUL1: begin
        mul_a = 32'($signed(up[pi]));
        mul_b = 32'($signed(up[pj]));
      end
      A_M_MUL2: begin
        mul_a = 32'($signed(ln[pi]));
        mul_b = 32'($signed(ln[pj]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // matrix assembly from the six symmetric terms, or the identity for a parallel pair
  always_comb begin
    case (it.code)
      CASE_PARALLEL: begin
        for (int k = 0; k < 9; k++) begin
          mr[k] = (k == 0 || k == 4 || k == 8) ? ONE28 : '0;
        end
      end
      CASE_ANTI: begin
        mr[0] = 28'($signed(m6[0]));
        mr[1] = 28'($signed(m6[1]));
        mr[2] = 28'($signed(m6[2]));
        mr[3] = 28'($signed(m6[1]));
        mr[4] = 28'($signed(m6[3]));
        mr[5] = 28'($signed(m6[4]));
        mr[6] = 28'($signed(m6[2]));
        mr[7] = 28'($signed(m6[4]));
        mr[8] = 28'($signed(m6[5]));
      end
      default: begin
        mr[0] = 28'($signed(it.ef)) + 28'($signed(m6[0]));
        mr[1] = 28'($signed(m6[1])) - 28'($signed(it.vf[2]));
        mr[2] = 28'($signed(m6[2])) + 28'($signed(it.vf[1]));
        mr[3] = 28'($signed(m6[1])) + 28'($signed(it.vf[2]));
        mr[4] = 28'($signed(it.ef)) + 28'($signed(m6[3]));
        mr[5] = 28'($signed(m6[4])) - 28'($signed(it.vf[0]));
        mr[6] = 28'($signed(m6[2])) - 28'($signed(it.vf[1]));
        mr[7] = 28'($signed(m6[4])) + 28'($signed(it.vf[0]));
        mr[8] = 28'($signed(it.ef)) + 28'($signed(m6[5]));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      prod <= 64'(mul_a) * 64'(mul_b);
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            for (int k = 0; k < 3; k++) begin
              ws[k] <= q_item.v[k][V_W-1];
              wm[k] <= 32'(q_item.v[k][V_W-1] ? -$signed(q_item.v[k])
                                              : $signed(q_item.v[k]));
            end
            case (q_item.code)
              CASE_PARALLEL: state <= B_DONE;
              CASE_ANTI:     state <= A_SQ_GO;
              default:       state <= G_SHIFT;
            endcase
          end
        end
        // shift all magnitudes together until the largest fits in 20 bits
        G_SHIFT: begin
          if (shift_more) begin
            for (int k = 0; k < 3; k++) begin
              wm[k] <= wm[k] >> 1;
            end
          end else begin
            cnt   <= '0;
            vv    <= '0;
            state <= G_VV_MUL;
          end
        end
        G_VV_MUL: state <= G_VV_ACC;
        G_VV_ACC: begin
          vv <= vv + DIV_DEN_W'(prod);
          if (cnt == 3'd2) begin
            cnt   <= '0;
            state <= G_Q_MUL;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= G_VV_MUL;
          end
        end
        G_Q_MUL: state <= G_Q_DIV;
        G_Q_DIV: begin
          qsign <= prod[63];
          if (vv == '0) begin
            qv    <= '0;
            state <= G_T_MUL;
          end else begin
            state <= G_Q_WAIT;
          end
        end
        G_Q_WAIT: begin
          if (div_done) begin
            qv    <= qsign ? -$signed(22'(div_quo)) : $signed(22'(div_quo));
            state <= G_T_MUL;
          end
        end
        G_T_MUL: state <= G_T_ACC;
        G_T_ACC: begin
          m6[cnt] <= 24'(rnd_shift(prod, 20));
          if (cnt == 3'd5) begin
            state <= B_DONE;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= G_Q_MUL;
          end
        end
        A_SQ_GO: state <= A_SQ_WAIT;
        A_SQ_WAIT: begin
          if (sq_done) begin
            root  <= sq_root;
            cnt   <= '0;
            state <= A_LN_DIV;
          end
        end
        A_LN_DIV: begin
          if (it.ll == '0) begin
            ln    <= '0;
            cnt   <= '0;
            state <= A_UP_MUL1;
          end else begin
            state <= A_LN_WAIT;
          end
        end
        A_LN_WAIT: begin
          if (div_done) begin
            ln[cnt[1:0]] <= lk[16] ? 27'(-$signed({1'b0, div_quo}))
                                   : 27'({1'b0, div_quo});
            if (cnt == 3'd2) begin
              cnt   <= '0;
              state <= A_UP_MUL1;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= A_LN_DIV;
            end
          end
        end
        A_UP_MUL1: state <= A_UP_MUL2;
        A_UP_MUL2: begin
          acc   <= 48'(prod);
          state <= A_UP_ACC;
        end
        A_UP_ACC: begin
          up[cnt[1:0]] <= 29'(rnd_shift(64'(acc) - prod, FRAC_BITS));
          if (cnt == 3'd2) begin
            cnt   <= '0;
            state <= A_M_MUL1;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= A_UP_MUL1;
          end
        end
        A_M_MUL1: state <= A_M_MUL2;
        A_M_MUL2: begin
          acc   <= 48'(rnd_shift(prod, 48 - FRAC_BITS));
          state <= A_M_ACC;
        end
        A_M_ACC: begin
          m6[cnt] <= 24'(64'(acc) - 64'($signed(it.ffr[cnt]))
                         - rnd_shift(prod, 48 - FRAC_BITS));
          if (cnt == 3'd5) begin
            state <= B_DONE;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= A_M_MUL1;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            m00       <= sat16(64'(mr[0]));
            m01       <= sat16(64'(mr[1]));
            m02       <= sat16(64'(mr[2]));
            m10       <= sat16(64'(mr[3]));
            m11       <= sat16(64'(mr[4]));
            m12       <= sat16(64'(mr[5]));
            m20       <= sat16(64'(mr[6]));
            m21       <= sat16(64'(mr[7]));
            m22       <= sat16(64'(mr[8]));
            case_code <= it.code;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/from_to_rotation_matrix.sv
// top level of the from-to rotation matrix block: epsilon register, front
// end, queue and back end; depends on ftrm_pkg, ftrm_front, ftrm_queue, ftrm_back
//
//  channel   handshake              payload
//  input     in_valid / in_ready    from_x from_y from_z to_x to_y to_z
//  result    out_valid / out_ready  m00 .. m22, case_code
//  config    cfg_we                 cfg_data (epsilon)
//
// the front end takes one vector pair per cycle while the four-entry queue has room
// the back end works on one queued item at a time: a parallel pair goes straight to the output, an
// antiparallel pair uses the square root and three divisions (no divisions with a zero left vector)
// and a general pair uses shift steps and six divisions (no divisions with a zero cross product)
// rst is synchronous: it empties the queue and pipeline and sets epsilon to 16
// a waiting result holds in the output register while the back end starts the next item
module from_to_rotation_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            from_x,
  input  logic signed [15:0]            from_y,
  input  logic signed [15:0]            from_z,
  input  logic signed [15:0]            to_x,
  input  logic signed [15:0]            to_y,
  input  logic signed [15:0]            to_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            m00,
  output logic signed [15:0]            m01,
  output logic signed [15:0]            m02,
  output logic signed [15:0]            m10,
  output logic signed [15:0]            m11,
  output logic signed [15:0]            m12,
  output logic signed [15:0]            m20,
  output logic signed [15:0]            m21,
  output logic signed [15:0]            m22,
  output logic [1:0]                    case_code,
  input  logic                          cfg_we,
  input  logic [ftrm_pkg::EPS_W-1:0]    cfg_data
);
  import ftrm_pkg::*;

  logic [EPS_W-1:0]   epsilon;
  logic               push;
  logic               pop;
  ftrm_item_t         front_item;
  ftrm_item_t         head_item;
  logic [QCNT_W-1:0]  q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_W'(EPS_RESET);
    end else if (cfg_we) begin
      epsilon <= cfg_data;
    end
  end

  ftrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .from_x   (from_x),
    .from_y   (from_y),
    .from_z   (from_z),
    .to_x     (to_x),
    .to_y     (to_y),
    .to_z     (to_z),
    .epsilon  (epsilon),
    .q_count  (q_count),
    .push     (push),
    .item     (front_item)
  );

  ftrm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .pop   (pop),
    .rdata (head_item),
    .count (q_count)
  );

  ftrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_count != '0),
    .q_item    (head_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .m00       (m00),
    .m01       (m01),
    .m02       (m02),
    .m10       (m10),
    .m11       (m11),
    .m12       (m12),
    .m20       (m20),
    .m21       (m21),
    .m22       (m22),
    .case_code (case_code)
  );

endmodule

// File: bench/from_to_rotation_matrix_tb.sv
// testbench for from_to_rotation_matrix: random and directed vector pairs, scoreboard check
// depends on ftrm_pkg and the rtl of the block
module from_to_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftrm_pkg::*;

  typedef struct {
    logic [15:0] m [9];
    case_t       code;
  } rot_t;

  // scoreboard: predicts each transaction, checks results in order
  class rot_scoreboard;
    rot_t        pending[$];
    int          errors;
    logic [14:0] eps;

    function new();
      errors = 0;
      eps = 15'(EPS_RESET);
    endfunction

    static function longint rsh(longint x, int s);
      longint m;
      m = x < 0 ? -x : x;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return x < 0 ? -m : m;
    endfunction

    static function longint rdiv(longint n, longint d);
      longint m;
      m = n < 0 ? -n : n;
      m = (m + d / 2) / d;
      return n < 0 ? -m : m;
    endfunction

    static function longint isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return longint'(r);
    endfunction

    static function logic [15:0] clip(longint x);
      if (x > 32767) return 16'h7fff;
      if (x < -32768) return 16'h8000;
      return x[15:0];
    endfunction

    function void note_input(logic signed [15:0] fv[3], logic signed [15:0] tv[3]);
      longint f[3], t[3], v[3], mm[3][3], e, one2, epsf;
      longint l[3], ln[3], up[3], ll, r, ef, vf[3], w[3], q[3][3], d, vv, a, k;
      int s;
      rot_t rt;
      for (int i = 0; i < 3; i++) begin
        f[i] = longint'(fv[i]);
        t[i] = longint'(tv[i]);
      end
      v[0] = f[1] * t[2] - f[2] * t[1];
      v[1] = f[2] * t[0] - f[0] * t[2];
      v[2] = f[0] * t[1] - f[1] * t[0];
      e = f[0] * t[0] + f[1] * t[1] + f[2] * t[2];
      one2 = longint'(1) << (2 * FRAC_BITS);
      epsf = longint'(eps) << FRAC_BITS;
      if (e > one2 - epsf) begin
        rt.code = CASE_PARALLEL;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            mm[i][j] = (i == j) ? (longint'(1) << FRAC_BITS) : longint'(0);
      end else if (e < -one2 + epsf) begin
        rt.code = CASE_ANTI;
        l[0] = 0; l[1] = f[2]; l[2] = -f[1];
        if (f[1] * f[1] + f[2] * f[2] < epsf) begin
          l[0] = -f[2]; l[1] = 0; l[2] = f[0];
        end
        ll = l[0] * l[0] + l[1] * l[1] + l[2] * l[2];
        if (ll == 0) begin
          for (int i = 0; i < 3; i++) ln[i] = 0;
        end else begin
          r = isqrt(longint'(ll) << 30);
          for (int i = 0; i < 3; i++) ln[i] = rdiv(l[i] * (longint'(1) << 39), r);
        end
        up[0] = rsh(ln[1] * f[2] - ln[2] * f[1], FRAC_BITS);
        up[1] = rsh(ln[2] * f[0] - ln[0] * f[2], FRAC_BITS);
        up[2] = rsh(ln[0] * f[1] - ln[1] * f[0], FRAC_BITS);
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            mm[i][j] = -rsh(f[i] * f[j], FRAC_BITS) + rsh(up[i] * up[j], 48 - FRAC_BITS)
                       - rsh(ln[i] * ln[j], 48 - FRAC_BITS);
      end else begin
        rt.code = CASE_GENERAL;
        ef = rsh(e, FRAC_BITS);
        a = 0;
        for (int i = 0; i < 3; i++) begin
          vf[i] = rsh(v[i], FRAC_BITS);
          k = v[i] < 0 ? -v[i] : v[i];
          if (k > a) a = k;
        end
        s = 0;
        while ((a >>> s) >= (longint'(1) << 20)) s++;
        for (int i = 0; i < 3; i++) begin
          k = (v[i] < 0 ? -v[i] : v[i]) >>> s;
          w[i] = v[i] < 0 ? -k : k;
        end
        vv = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
        d = (longint'(1) << FRAC_BITS) - ef;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            q[i][j] = vv == 0 ? 0 : rdiv(w[i] * w[j] * (longint'(1) << 20), vv);
            mm[i][j] = rsh(d * q[i][j], 20) + (i == j ? ef : 0);
          end
        mm[0][1] -= vf[2]; mm[1][0] += vf[2];
        mm[0][2] += vf[1]; mm[2][0] -= vf[1];
        mm[1][2] -= vf[0]; mm[2][1] += vf[0];
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) rt.m[i * 3 + j] = clip(mm[i][j]);
      pending.push_back(rt);
    endfunction

    function void check_result(logic [15:0] got[9], logic [1:0] code);
      rot_t x;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      x = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i] !== x.m[i]) begin
          $error("m%0d%0d expected %h actual %h", i / 3, i % 3, x.m[i], got[i]);
          errors++;
        end
      if (code !== x.code) begin
        $error("case_code expected %0d actual %0d", x.code, code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic in_ready, out_valid;
  logic signed [15:0] from_x = 0, from_y = 0, from_z = 0, to_x = 0, to_y = 0, to_z = 0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic [1:0] case_code;
  logic [EPS_W-1:0] cfg_data = 0;
  int send_idle = 30, recv_idle = 46;
  rot_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  from_to_rotation_matrix u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .from_x(from_x), .from_y(from_y), .from_z(from_z),
    .to_x(to_x), .to_y(to_y), .to_z(to_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .case_code(case_code),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // receiver: random stalls, check at the edge
  always @(posedge clk) begin
    logic [15:0] got[9];
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        sb.check_result(got, case_code);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // valid stays high after an accept until the next idle cycle or drain
  task automatic send_pair(logic signed [15:0] f[3], logic signed [15:0] t[3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {from_x, from_y, from_z} <= {f[0], f[1], f[2]};
    {to_x, to_y, to_z} <= {t[0], t[1], t[2]};
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_eps(logic [14:0] val);
    cfg_we <= 1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.eps = val;
  endtask

  function automatic logic signed [15:0] comp();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 0;
      default: return $signed(16'($urandom_range(32767))) - 16'sd16384;
    endcase
  endfunction

  // near-unit vectors so the geometric cases are hit
  task automatic rand_pair();
    logic signed [15:0] f[3], t[3];
    int kind, ax;
    ax = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      f[i] = (i == ax) ? 16'(16384 - $urandom_range(300)) : 16'($urandom_range(600) - 300);
      if ($urandom_range(1)) f[i] = -f[i];
    end
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++)
      case (kind)
        0, 1: t[i] = 16'(f[i] + $signed(16'($urandom_range(6))) - 3);
        2, 3: t[i] = 16'(-f[i] + $signed(16'($urandom_range(6))) - 3);
        4: t[i] = comp();
        default: t[i] = $signed(16'($urandom_range(20000))) - 16'sd10000;
      endcase
    if (kind == 4) for (int i = 0; i < 3; i++) f[i] = comp();
    send_pair(f, t);
  endtask

  task automatic directed();
    logic signed [15:0] f[3], t[3];
    f = '{16384, 0, 0}; t = '{16384, 0, 0}; send_pair(f, t);
    t = '{-16384, 0, 0}; send_pair(f, t);
    t = '{0, 16384, 0}; send_pair(f, t);
    f = '{0, 16384, 0}; t = '{0, -16384, 0}; send_pair(f, t);
    f = '{0, 0, 16384}; t = '{0, 0, -16384}; send_pair(f, t);
    f = '{0, 0, 0}; t = '{0, 0, 0}; send_pair(f, t);
    f = '{-32768, -32768, -32768}; t = '{32767, 32767, 32767}; send_pair(f, t);
    t = '{-32768, -32768, -32768}; send_pair(f, t);
    f = '{32767, -32768, 32767}; t = '{-32768, 32767, 0}; send_pair(f, t);
    f = '{9459, 9459, 9459}; t = '{-9459, -9459, -9459}; send_pair(f, t);
    f = '{11585, 11585, 0}; t = '{0, 11585, 11585}; send_pair(f, t);
    f = '{16384, 1, 0}; t = '{16384, 0, 1}; send_pair(f, t);
    f = '{16384, 0, 0}; t = '{16384, 0, 0}; send_pair(f, t);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    drain();
    set_eps(15'd0);
    directed();
    drain();
    set_eps(15'd16384);
    directed();
    drain();
    set_eps(15'd16);
    for (int n = 0; n < 1700; n++) begin
      if (n == 600) begin
        drain();
        send_idle = 46;
        recv_idle = 30;
        set_eps(15'($urandom_range(400)));
      end
      if (n == 1100) begin
        drain();
        send_idle = 0;
        recv_idle = 0;
        set_eps(15'd32767);
      end
      if (n == 1300) begin
        drain();
        set_eps(15'd4);
      end
      rand_pair();
    end
    drain();
    if (sb.errors == 0) $display("from_to_rotation_matrix_tb: PASS");
    else $display("from_to_rotation_matrix_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("from_to_rotation_matrix_tb: FAIL");
    $finish;
  end
endmodule
